// File: rtl/hbkd_pkg.sv
// ----------------------------------------------------------------------------
// hbkd_pkg
// shared types and constants of the boot keyboard report differ
// ----------------------------------------------------------------------------
`default_nettype none

package hbkd_pkg;

  localparam int unsigned ModBits     = 8;
  localparam int unsigned InKeyFields = 6;
  localparam logic [6:0]  MinReportLen = 7'd8;
  localparam logic [7:0]  NoKeyMax     = 8'd3;

  typedef struct packed {
    logic [6:0] report_length;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
  } in_item_t;

  typedef struct packed {
    logic       is_modifier;
    logic [7:0] event_code;
    logic       pressed;
    logic       last_event;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// File: rtl/hbkd_fifo.sv
// ----------------------------------------------------------------------------
// hbkd_fifo
// two-entry job queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module hbkd_fifo #(
  parameter int unsigned Width = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [Width-1:0]      push_data_i,
  input  logic                  pop_i,
  output logic [Width-1:0]      pop_data_o,
  output hbkd_pkg::fifo_status_t status_o
);
  import hbkd_pkg::*;

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o     = mem_q[rd_ptr_q];
  assign status_o.full  = cnt_q[1];
  assign status_o.empty = (cnt_q == 2'd0);

endmodule

`default_nettype wire

// File: rtl/hbkd_front.sv
// ----------------------------------------------------------------------------
// hbkd_front
// accepts reports, diffs them against the stored report, queues event jobs
// ----------------------------------------------------------------------------
`default_nettype none

module hbkd_front #(
  parameter int unsigned KeySlots = 6,
  parameter int unsigned EvW      = 8 + 2 * KeySlots,
  parameter int unsigned JobW     = EvW + 8 + 16 * KeySlots
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  hbkd_pkg::in_item_t     in_item_i,
  input  hbkd_pkg::fifo_status_t fifo_status_i,
  output logic                   push_o,
  output logic [JobW-1:0]        job_o
);
  import hbkd_pkg::*;

  typedef struct packed {
    logic [EvW-1:0]             mask;
    logic [7:0]                 mods;
    logic [KeySlots-1:0][7:0]   old_keys;
    logic [KeySlots-1:0][7:0]   new_keys;
  } job_t;

  logic [7:0]               prev_mods_q;
  logic [KeySlots-1:0][7:0] prev_keys_q;
  logic [KeySlots-1:0][7:0] new_keys;
  logic [InKeyFields-1:0][7:0] in_keys;
  logic [EvW-1:0]           mask;
  logic                     accept;
  logic                     long_report;
  job_t                     job;

  assign in_keys = {in_item_i.key_slot_5, in_item_i.key_slot_4, in_item_i.key_slot_3,
                    in_item_i.key_slot_2, in_item_i.key_slot_1, in_item_i.key_slot_0};

  // slots beyond the report's six fields read as no key
  for (genvar g = 0; g < KeySlots; g++) begin : g_keys
    if (g < InKeyFields) begin : g_in
      assign new_keys[g] = in_keys[g];
    end else begin : g_zero
      assign new_keys[g] = 8'd0;
    end
  end

  always_comb begin
    logic old_seen;
    logic new_seen;
    mask = '0;
    mask[ModBits-1:0] = prev_mods_q ^ in_item_i.modifier_bits;
    for (int i = 0; i < KeySlots; i++) begin
      old_seen = 1'b0;
      new_seen = 1'b0;
      for (int j = 0; j < KeySlots; j++) begin
        if (new_keys[j] == prev_keys_q[i]) begin
          old_seen = 1'b1;
        end
        if (prev_keys_q[j] == new_keys[i]) begin
          new_seen = 1'b1;
        end
      end
      mask[ModBits + 2 * i]     = (prev_keys_q[i] > NoKeyMax) && !old_seen;
      mask[ModBits + 2 * i + 1] = (new_keys[i] > NoKeyMax) && !new_seen;
    end
  end

  assign in_ready_o  = !fifo_status_i.full;
  assign accept      = in_valid_i && in_ready_o;
  assign long_report = (in_item_i.report_length >= MinReportLen);
  assign push_o      = accept && long_report && (|mask);

  always_comb begin
    job.mask     = mask;
    job.mods     = in_item_i.modifier_bits;
    job.old_keys = prev_keys_q;
    job.new_keys = new_keys;
  end
  assign job_o = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mods_q <= '0;
      prev_keys_q <= '0;
    end else if (accept && long_report) begin
      prev_mods_q <= in_item_i.modifier_bits;
      prev_keys_q <= new_keys;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hbkd_back.sv
// ----------------------------------------------------------------------------
// hbkd_back
// walks a queued job's event mask and emits one event per cycle while out_ready_i does not stall the output
// ----------------------------------------------------------------------------
`default_nettype none

module hbkd_back #(
  parameter int unsigned KeySlots = 6,
  parameter int unsigned EvW      = 8 + 2 * KeySlots,
  parameter int unsigned JobW     = EvW + 8 + 16 * KeySlots
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hbkd_pkg::fifo_status_t fifo_status_i,
  input  logic [JobW-1:0]        job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output hbkd_pkg::out_item_t    out_item_o
);
  import hbkd_pkg::*;

  typedef struct packed {
    logic [EvW-1:0]             mask;
    logic [7:0]                 mods;
    logic [KeySlots-1:0][7:0]   old_keys;
    logic [KeySlots-1:0][7:0]   new_keys;
  } job_t;

  job_t                     job_in;
  logic [EvW-1:0]           mask_q, mask_d;
  logic [7:0]               mods_q;
  logic [KeySlots-1:0][7:0] old_q;
  logic [KeySlots-1:0][7:0] new_q;
  logic [EvW-1:0]           sel;
  logic [EvW-1:0]           rest;
  logic                     active;
  logic                     advance;
  logic                     emit;
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q;
  out_item_t                evt;

  assign job_in  = job_i;
  assign active  = |mask_q;
  assign advance = !out_valid_q || out_ready_i;
  assign emit    = active && advance;

  // lowest pending event first
  assign sel  = mask_q & (~mask_q + EvW'(1));
  assign rest = mask_q & ~sel;

  always_comb begin
    evt             = '0;
    evt.is_modifier = |sel[ModBits-1:0];
    evt.last_event  = (rest == '0);
    for (int b = 0; b < ModBits; b++) begin
      if (sel[b]) begin
        evt.event_code = 8'(b);
        evt.pressed    = mods_q[b];
      end
    end
    for (int i = 0; i < KeySlots; i++) begin
      if (sel[ModBits + 2 * i]) begin
        evt.event_code = old_q[i];
        evt.pressed    = 1'b0;
      end
      if (sel[ModBits + 2 * i + 1]) begin
        evt.event_code = new_q[i];
        evt.pressed    = 1'b1;
      end
    end
  end

  assign pop_o = !fifo_status_i.empty && (!active || (emit && (rest == '0)));

  always_comb begin
    mask_d = mask_q;
    if (emit) begin
      mask_d = rest;
    end
    if (pop_o) begin
      mask_d = job_in.mask;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (advance) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      mods_q <= job_in.mods;
      old_q  <= job_in.old_keys;
      new_q  <= job_in.new_keys;
    end
    if (emit) begin
      out_q <= evt;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// File: rtl/hid_boot_keyboard_report_diff_core.sv
// first event of a report goes through the job queue and the back part's mask register into the output register
// then one event per cycle while out_ready_i does not stall the output register
// reports with no events or a short length never reach the back part
// the input stalls only while the two-entry job queue is full
// reset clears the stored report to all zero, empties the queue and the output register
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_diff_core
// boot keyboard report differ: turns each report into modifier and key events
// ----------------------------------------------------------------------------
`default_nettype none

module hid_boot_keyboard_report_diff_core #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hbkd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hbkd_pkg::out_item_t out_item_o
);
  import hbkd_pkg::*;

  // one mask bit per modifier, then a release and a press bit per slot
  localparam int unsigned EvW  = ModBits + 2 * KEY_SLOTS;
  // mask, new modifier byte, old and new key slots
  localparam int unsigned JobW = EvW + 8 + 16 * KEY_SLOTS;

  logic         push;
  logic         pop;
  logic [JobW-1:0] push_job;
  logic [JobW-1:0] pop_job;
  fifo_status_t fifo_status;

  // front: takes reports, keeps the last long report, builds the event mask
  hbkd_front #(
    .KeySlots (KEY_SLOTS),
    .EvW      (EvW),
    .JobW     (JobW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_item_i     (in_item_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .job_o         (push_job)
  );

  // short queue so the front keeps taking reports while events drain
  hbkd_fifo #(
    .Width (JobW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .pop_i       (pop),
    .pop_data_o  (pop_job),
    .status_o    (fifo_status)
  );

  // back: walks the mask lowest bit first into the output register
  hbkd_back #(
    .KeySlots (KEY_SLOTS),
    .EvW      (EvW),
    .JobW     (JobW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .job_i         (pop_job),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item_o)
  );

`ifndef SYNTH
  // no job is pushed into a full queue
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !fifo_status.full)
    else $error("job pushed into full queue");

  // no job is popped from an empty queue
  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !fifo_status.empty)
    else $error("job popped from empty queue");

  // a short report never produces a job
  a_short_dropped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_item_i.report_length < MinReportLen)) |-> !push)
    else $error("short report queued");
`endif

endmodule

`default_nettype wire
